// ----- src/vec3_pkg.sv -----
// Shared types, constants and helper functions of the three-component vector ALU.
// Used by vec3_arithmetic_unit and its port checker; depends on nothing else.
package vec3_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int WIDE_BITS = 2 * WORD_BITS + 2;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
    localparam int SQRT_BITS = WORD_BITS;

    localparam logic [3:0] FN_ADD       = 4'd0;
    localparam logic [3:0] FN_SUB       = 4'd1;
    localparam logic [3:0] FN_MUL       = 4'd2;
    localparam logic [3:0] FN_DIV       = 4'd3;
    localparam logic [3:0] FN_SCALE     = 4'd4;
    localparam logic [3:0] FN_DIVSCALAR = 4'd5;
    localparam logic [3:0] FN_NEGATE    = 4'd6;
    localparam logic [3:0] FN_DOT       = 4'd7;
    localparam logic [3:0] FN_CROSS     = 4'd8;
    localparam logic [3:0] FN_LENSQ     = 4'd9;
    localparam logic [3:0] FN_LEN       = 4'd10;
    localparam logic [3:0] FN_NORMALIZE = 4'd11;
    localparam logic [3:0] FN_LERP      = 4'd12;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [3:0]                  func;
        logic signed [WORD_BITS-1:0] a_x;
        logic signed [WORD_BITS-1:0] a_y;
        logic signed [WORD_BITS-1:0] a_z;
        logic signed [WORD_BITS-1:0] b_x;
        logic signed [WORD_BITS-1:0] b_y;
        logic signed [WORD_BITS-1:0] b_z;
        logic signed [WORD_BITS-1:0] scalar_in;
    } req_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] r_x;
        logic signed [WORD_BITS-1:0] r_y;
        logic signed [WORD_BITS-1:0] r_z;
        logic signed [WORD_BITS-1:0] scalar_out;
        logic [1:0]                  status;
    } res_t;

    typedef struct packed {
        logic                 ov;
        logic [WORD_BITS-1:0] val;
    } sat_t;

    // Clamp a wide signed value to the word range, flagging any clamp.
    function automatic sat_t sat_word(input logic signed [WIDE_BITS-1:0] v);
        sat_t res;
        res.ov  = (v[WIDE_BITS-1:WORD_BITS-1] != {(WIDE_BITS-WORD_BITS+1){1'b0}}) &&
                  (v[WIDE_BITS-1:WORD_BITS-1] != {(WIDE_BITS-WORD_BITS+1){1'b1}});
        res.val = res.ov ? (v[WIDE_BITS-1] ? WORD_MIN : WORD_MAX) : v[WORD_BITS-1:0];
        return res;
    endfunction

    // Magnitude as an unsigned word; the most negative value maps to its true size.
    function automatic logic [WORD_BITS-1:0] abs_word(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ----- src/vec3_arithmetic_unit.sv -----
// Pipelined three-component Q16.16 vector ALU.
// Depends on vec3_pkg for the request/result structs, operation codes and helpers.
//
//  channel | signals                           | direction | accepted when
//  request | req_valid, req_ready, req_data    | in        | req_valid && req_ready
//  result  | res_valid, res_ready, res_data    | out       | res_valid && res_ready
//
// One request enters per cycle unless a stalled result holds the pipeline; results leave in request order.
// The pipeline holds the square root (32 stages, one root bit each) followed by
// the three parallel dividers (48 stages, one quotient bit each).
// Reset clears only the valid bits. A stalled result freezes the whole pipeline,
// so req_ready follows res_ready whenever a result is waiting.
module vec3_arithmetic_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  vec3_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_ready,
    output vec3_pkg::res_t res_data
);

    localparam int W   = vec3_pkg::WORD_BITS;
    localparam int F   = vec3_pkg::FRAC_BITS;
    localparam int WD  = vec3_pkg::WIDE_BITS;
    localparam int PB  = vec3_pkg::PROD_BITS;
    localparam int DB  = vec3_pkg::DIV_BITS;
    localparam int SQ  = vec3_pkg::SQRT_BITS;
    localparam int NST = SQ + DB;

    typedef struct packed {
        logic [3:0]           func;
        logic [2:0][W-1:0]    r;
        logic [W-1:0]         sc;
        logic                 ov;
        logic [2:0][W-1:0]    nmag;
        logic [2:0]           nneg;
        logic [2:0][W-1:0]    dvs;
        logic [2:0]           dneg;
        logic [PB-1:0]        rad;
        logic [SQ-1:0]        root;
        logic [2:0][DB-1:0]   q;
        logic [2:0][W-1:0]    drem;
    } pl_t;

    logic                  en;
    logic                  in_vld_reg;
    vec3_pkg::req_t        in_reg;
    logic                  p_vld_reg;
    vec3_pkg::req_t        pf_reg;
    logic signed [PB-1:0]  p_reg [6];
    logic signed [PB-1:0]  p_next [6];
    logic signed [W-1:0]   ma [6];
    logic signed [W-1:0]   mb [6];
    logic [NST:0]          pl_vld_reg;
    pl_t                   pl_reg [NST+1];
    pl_t                   pl_next [NST+1];
    logic                  res_vld_reg;
    vec3_pkg::res_t        res_reg;
    vec3_pkg::res_t        res_next;

    assign en        = !res_vld_reg || res_ready;
    assign req_ready = en;
    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

    // Operand routing onto the six multipliers.
    always_comb
    begin
        logic signed [W-1:0] a [3];
        logic signed [W-1:0] b [3];
        a = '{in_reg.a_x, in_reg.a_y, in_reg.a_z};
        b = '{in_reg.b_x, in_reg.b_y, in_reg.b_z};
        for (int i = 0; i < 3; i++)
        begin
            ma[i]   = a[i];
            mb[i]   = b[i];
            ma[i+3] = '0;
            mb[i+3] = '0;
        end
        case (in_reg.func)
            vec3_pkg::FN_SCALE:
            begin
                for (int i = 0; i < 3; i++) mb[i] = in_reg.scalar_in;
            end
            vec3_pkg::FN_LENSQ, vec3_pkg::FN_LEN, vec3_pkg::FN_NORMALIZE:
            begin
                for (int i = 0; i < 3; i++) mb[i] = a[i];
            end
            vec3_pkg::FN_CROSS:
            begin
                ma = '{a[1], a[2], a[0], a[2], a[0], a[1]};
                mb = '{b[2], b[0], b[1], b[1], b[2], b[0]};
            end
            vec3_pkg::FN_LERP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i]   = in_reg.scalar_in;
                    mb[i]   = a[i];
                    ma[i+3] = in_reg.scalar_in;
                    mb[i+3] = b[i];
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 6; i++) p_next[i] = PB'(ma[i]) * PB'(mb[i]);
    end

    // Combine products and sums, saturate, and prepare the divider operands.
    always_comb
    begin
        logic signed [W-1:0]  a [3];
        logic signed [W-1:0]  b [3];
        logic signed [WD-1:0] w [3];
        logic signed [WD-1:0] sw;
        logic signed [WD-1:0] fl [6];
        vec3_pkg::sat_t       st;
        pl_t                  o;
        a = '{pf_reg.a_x, pf_reg.a_y, pf_reg.a_z};
        b = '{pf_reg.b_x, pf_reg.b_y, pf_reg.b_z};
        for (int i = 0; i < 6; i++) fl[i] = WD'(p_reg[i] >>> F);
        o      = '0;
        o.func = pf_reg.func;
        sw     = '0;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = '0;
            case (pf_reg.func)
                vec3_pkg::FN_ADD:    w[i] = WD'(a[i]) + WD'(b[i]);
                vec3_pkg::FN_SUB:    w[i] = WD'(a[i]) - WD'(b[i]);
                vec3_pkg::FN_NEGATE: w[i] = -WD'(a[i]);
                vec3_pkg::FN_MUL, vec3_pkg::FN_SCALE: w[i] = fl[i];
                vec3_pkg::FN_CROSS:  w[i] = fl[i] - fl[i+3];
                // Floor of the negated product, as in a - s*a + s*b.
                vec3_pkg::FN_LERP:
                    w[i] = WD'(a[i]) + ((-WD'(p_reg[i])) >>> F) + fl[i+3];
                default:             w[i] = '0;
            endcase
            st      = vec3_pkg::sat_word(w[i]);
            o.r[i]  = st.val;
            o.ov    = o.ov | st.ov;
            o.nmag[i] = vec3_pkg::abs_word(a[i]);
            o.nneg[i] = a[i][W-1];
            if (pf_reg.func == vec3_pkg::FN_DIV)
            begin
                o.dvs[i]  = vec3_pkg::abs_word(b[i]);
                o.dneg[i] = b[i][W-1];
            end
            else
            begin
                o.dvs[i]  = vec3_pkg::abs_word(pf_reg.scalar_in);
                o.dneg[i] = pf_reg.scalar_in[W-1];
            end
        end
        if (pf_reg.func inside {vec3_pkg::FN_DOT, vec3_pkg::FN_LENSQ})
        begin
            sw   = fl[0] + fl[1] + fl[2];
            st   = vec3_pkg::sat_word(sw);
            o.sc = st.val;
            o.ov = o.ov | st.ov;
        end
        o.rad      = PB'(p_reg[0]) + PB'(p_reg[1]) + PB'(p_reg[2]);
        pl_next[0] = o;
    end

    for (genvar j = 1; j <= NST; j++)
    begin : g_st
        if (j <= SQ)
        begin : g_sq
            localparam int B = SQ - j;
            always_comb
            begin
                logic [WD-1:0] d;
                pl_t           o;
                o = pl_reg[j-1];
                // Try root bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B).
                d = (WD'(o.root) << (B + 1)) | (WD'(1) << (2 * B));
                if (WD'(o.rad) >= d)
                begin
                    o.rad  = PB'(WD'(o.rad) - d);
                    o.root = o.root | (SQ'(1) << B);
                end
                pl_next[j] = o;
            end
        end
        else
        begin : g_dv
            localparam int K = j - SQ - 1;
            always_comb
            begin
                logic [DB-1:0] n;
                logic [W:0]    r1;
                pl_t           o;
                o = pl_reg[j-1];
                if (K == 0)
                begin
                    // The length is now known: finish len and feed normalize.
                    if (o.func == vec3_pkg::FN_LEN)
                    begin
                        o.sc = o.root[SQ-1] ? vec3_pkg::WORD_MAX : W'(o.root);
                        o.ov = o.ov | o.root[SQ-1];
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        if (o.func == vec3_pkg::FN_NORMALIZE)
                        begin
                            o.dvs[i]  = W'(o.root);
                            o.dneg[i] = 1'b0;
                        end
                        o.q[i]    = '0;
                        o.drem[i] = '0;
                    end
                end
                for (int i = 0; i < 3; i++)
                begin
                    n  = {o.nmag[i], {F{1'b0}}};
                    r1 = {o.drem[i], n[DB-1-K]};
                    if (r1 >= {1'b0, o.dvs[i]})
                    begin
                        o.drem[i]          = W'(r1 - {1'b0, o.dvs[i]});
                        o.q[i][DB-1-K]     = 1'b1;
                    end
                    else
                    begin
                        o.drem[i] = r1[W-1:0];
                    end
                end
                pl_next[j] = o;
            end
        end
    end

    // Sign and saturate the quotients, then assemble the result.
    always_comb
    begin
        logic signed [WD-1:0] qs;
        logic                 dz;
        logic                 ov;
        logic                 isdiv;
        vec3_pkg::sat_t       st;
        logic [2:0][W-1:0]    r;
        pl_t                  c;
        c     = pl_reg[NST];
        dz    = 1'b0;
        ov    = c.ov;
        r     = c.r;
        isdiv = c.func inside {vec3_pkg::FN_DIV, vec3_pkg::FN_DIVSCALAR,
                               vec3_pkg::FN_NORMALIZE};
        for (int i = 0; i < 3; i++)
        begin
            qs = WD'({2'b00, c.q[i]});
            if (c.nneg[i] != c.dneg[i]) qs = -qs;
            st = vec3_pkg::sat_word(qs);
            if (isdiv)
            begin
                if (c.dvs[i] == '0)
                begin
                    dz   = 1'b1;
                    r[i] = (c.nmag[i] == '0) ? '0 :
                           (c.nneg[i] ? vec3_pkg::WORD_MIN : vec3_pkg::WORD_MAX);
                end
                else
                begin
                    r[i] = st.val;
                    ov   = ov | st.ov;
                end
            end
        end
        res_next.r_x        = r[0];
        res_next.r_y        = r[1];
        res_next.r_z        = r[2];
        res_next.scalar_out = c.sc;
        res_next.status     = dz ? vec3_pkg::ST_DIV_ZERO :
                              (ov ? vec3_pkg::ST_OVERFLOW : vec3_pkg::ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            pl_vld_reg  <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg  <= req_valid;
            p_vld_reg   <= in_vld_reg;
            pl_vld_reg  <= {pl_vld_reg[NST-1:0], p_vld_reg};
            res_vld_reg <= pl_vld_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= req_data;
            pf_reg <= in_reg;
            for (int i = 0; i < 6; i++) p_reg[i] <= p_next[i];
            for (int j = 0; j <= NST; j++) pl_reg[j] <= pl_next[j];
            res_reg <= res_next;
        end
    end

endmodule

// ----- src/vec3_chk.sv -----
// Port-level checker for vec3_arithmetic_unit, attached by the bind below.
// Depends on vec3_pkg for the payload structs and status codes.
module vec3_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input vec3_pkg::req_t req_data,
    input logic           res_valid,
    input logic           res_ready,
    input vec3_pkg::res_t res_data
);

    // A waiting result holds still until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // With no result waiting the pipeline must take a request.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request refused with empty output");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.status != 2'd3)
        else $error("undefined status code");

    // Division by zero only arises in vector operations, whose scalar is zero.
    a_dz_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status == vec3_pkg::ST_DIV_ZERO |-> res_data.scalar_out == '0)
        else $error("scalar set on a division result");

endmodule

bind vec3_arithmetic_unit vec3_chk u_chk (.*);
